// ----- hw/rtl/msep_pkg.sv -----
// shared types and constants for the sequence track event parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package msep_pkg;

	// event kinds carried on the result word
	localparam logic [3:0] KIND_NOTE_OFF     = 4'd0;
	localparam logic [3:0] KIND_NOTE_DUR     = 4'd1;
	localparam logic [3:0] KIND_KEY_PRESS    = 4'd2;
	localparam logic [3:0] KIND_CTRL         = 4'd3;
	localparam logic [3:0] KIND_PROG         = 4'd4;
	localparam logic [3:0] KIND_CHAN_PRESS   = 4'd5;
	localparam logic [3:0] KIND_BEND         = 4'd6;
	localparam logic [3:0] KIND_LOOP_END     = 4'd7;
	localparam logic [3:0] KIND_LOOP_START   = 4'd8;
	localparam logic [3:0] KIND_END          = 4'd9;
	localparam logic [3:0] KIND_TEMPO        = 4'd10;
	localparam logic [3:0] KIND_META         = 4'd11;
	localparam logic [3:0] KIND_SYS          = 4'd12;
	localparam logic [3:0] KIND_END_NO_DATA  = 4'd13;

	// meta types with special handling
	localparam logic [7:0] META_LOOP_END   = 8'h2D;
	localparam logic [7:0] META_LOOP_START = 8'h2E;
	localparam logic [7:0] META_END        = 8'h2F;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] STATUS_META     = 8'hFF;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  channel;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [31:0] value;
		logic [31:0] delta_time;
		logic [15:0] event_length;
	} event_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       past_end;
	} item_t;

endpackage

// ----- hw/rtl/midi_running_status_event_parser.sv -----
// top level: input register, byte parser and registered event output
// depends on msep_pkg, msep_in_stage, msep_parser
// a byte that closes an event is held in the input register, then registered as its word
// throughput: one byte per cycle while the output register is free to take a word
// a word held on the output still lets one more byte enter the input register
// reset (arst_n low) clears the parse state and empties both registers
`timescale 1ns / 1ps

module midi_running_status_event_parser
	import msep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        past_end,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [3:0]  event_kind,
	output logic [3:0]  channel,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [31:0] value,
	output logic [31:0] delta_time,
	output logic [15:0] event_length
);

	item_t  item_s1;
	logic   out_free;
	logic   advance;
	logic   ev_valid;
	event_t ev;
	logic   out_valid_q;
	event_t out_q;

	assign out_free = !out_valid_q || !event_stall;
	assign advance  = item_s1.valid && out_free;

	msep_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.data_byte  (data_byte),
		.past_end   (past_end),
		.advance    (advance),
		.item_s1    (item_s1)
	);

	msep_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (item_s1.data_byte),
		.past_end  (item_s1.past_end),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_valid) begin
			out_q <= ev;
		end
	end

	assign event_valid  = out_valid_q;
	assign event_kind   = out_q.kind;
	assign channel      = out_q.channel;
	assign first_data   = out_q.first_data;
	assign second_data  = out_q.second_data;
	assign value        = out_q.value;
	assign delta_time   = out_q.delta_time;
	assign event_length = out_q.event_length;

endmodule

// ----- hw/rtl/msep_in_stage.sv -----
// input register stage: holds one accepted byte until the parser takes it
// depends on msep_pkg
`timescale 1ns / 1ps

module msep_in_stage
	import msep_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic       past_end,
	input  logic       advance,
	output item_t      item_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       pe_s1;
	logic       take;

	// the stage is free when empty or being drained this cycle
	assign item_stall = valid_s1 && !advance;
	assign take = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
			pe_s1   <= past_end;
		end
	end

	assign item_s1 = '{valid: valid_s1, data_byte: byte_s1, past_end: pe_s1};

endmodule

// ----- hw/rtl/msep_parser.sv -----
// parse state and per-byte decode; gives at most one event per byte
// depends on msep_pkg
`timescale 1ns / 1ps

module msep_parser
	import msep_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       past_end,
	output logic       ev_valid,
	output event_t     ev
);

	localparam logic [2:0] PH_DELTA  = 3'd0;
	localparam logic [2:0] PH_STATUS = 3'd1;
	localparam logic [2:0] PH_FIRST  = 3'd2;
	localparam logic [2:0] PH_SECOND = 3'd3;
	localparam logic [2:0] PH_DUR    = 3'd4;
	localparam logic [2:0] PH_SKIP   = 3'd5;
	localparam logic [2:0] PH_TEMPO  = 3'd6;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  rs_q, rs_n;
	logic [3:0]  chan_q, chan_n;
	logic [31:0] delta_q, delta_n;
	logic [31:0] val_q, val_n;
	logic [7:0]  first_q, first_n;
	logic [7:0]  second_q, second_n;
	logic [7:0]  meta_q, meta_n;
	logic [2:0]  skip_q, skip_n;
	logic [15:0] count_q, count_n;
	logic        ended_q, ended_n;

	logic [7:0]  b;
	logic        give;
	logic        do_first;
	logic [3:0]  g_kind;
	logic [7:0]  g_first;
	logic [7:0]  g_second;
	logic [31:0] g_val;
	logic [15:0] g_len;
	logic [2:0]  skip_dec;

	assign b = past_end ? 8'h00 : data_byte;
	assign skip_dec = (skip_q != 3'd0) ? skip_q - 3'd1 : 3'd0;

	always_comb begin
		phase_n  = phase_q;
		rs_n     = rs_q;
		chan_n   = chan_q;
		delta_n  = delta_q;
		val_n    = val_q;
		first_n  = first_q;
		second_n = second_q;
		meta_n   = meta_q;
		skip_n   = skip_q;
		count_n  = count_q;
		ended_n  = ended_q;
		give     = 1'b0;
		do_first = 1'b0;
		g_kind   = KIND_NOTE_OFF;
		g_first  = 8'h00;
		g_second = 8'h00;
		g_val    = 32'd0;
		g_len    = 16'd0;

		if (ended_q) begin
			// track over: bytes are dropped
		end else if (phase_q == PH_DELTA && count_q == 16'd0 && past_end) begin
			give    = 1'b1;
			g_kind  = KIND_END_NO_DATA;
			ended_n = 1'b1;
		end else begin
			if (count_q != COUNT_MAX) begin
				count_n = count_q + 16'd1;
			end
			case (phase_q)
				PH_DELTA: begin
					delta_n = {delta_q[24:0], b[6:0]};
					if (!b[7]) begin
						phase_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (!b[7]) begin
						if (rs_q == 8'h00) begin
							// data byte with no running status ends the track
							give    = 1'b1;
							g_kind  = KIND_END;
							ended_n = 1'b1;
						end else begin
							do_first = 1'b1;
						end
					end else begin
						rs_n = b;
						if (b inside {[8'h80:8'hEF]}) begin
							chan_n = b[3:0];
						end
						if (b[7:4] == 4'hF && b != STATUS_META) begin
							give   = 1'b1;
							g_kind = KIND_SYS;
							g_len  = count_n;
						end else begin
							phase_n = PH_FIRST;
						end
					end
				end
				PH_FIRST: begin
					do_first = 1'b1;
				end
				PH_SECOND: begin
					second_n = b;
					g_first  = first_q;
					g_second = b;
					g_len    = count_n;
					case (rs_q[7:4])
						4'h9: begin
							val_n   = 32'd0;
							phase_n = PH_DUR;
						end
						4'h8: begin
							give   = 1'b1;
							g_kind = KIND_NOTE_OFF;
						end
						4'hA: begin
							give   = 1'b1;
							g_kind = KIND_KEY_PRESS;
						end
						4'hB: begin
							give   = 1'b1;
							g_kind = KIND_CTRL;
						end
						default: begin
							give   = 1'b1;
							g_kind = KIND_BEND;
						end
					endcase
				end
				PH_DUR: begin
					val_n = {val_q[24:0], b[6:0]};
					if (!b[7]) begin
						give    = 1'b1;
						g_first = first_q;
						g_len   = count_n;
						// zero velocity turns the note into a note off
						if (second_q == 8'h00) begin
							g_kind = KIND_NOTE_OFF;
						end else begin
							g_kind   = KIND_NOTE_DUR;
							g_second = second_q;
							g_val    = val_n;
						end
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 3'd0) begin
						give    = 1'b1;
						g_kind  = (meta_q == META_LOOP_END) ? KIND_LOOP_END : KIND_LOOP_START;
						g_first = meta_q;
						g_len   = count_n;
					end
				end
				PH_TEMPO: begin
					val_n  = {8'h00, val_q[15:0], b};
					skip_n = skip_dec;
					if (skip_dec == 3'd0) begin
						give    = 1'b1;
						g_kind  = KIND_TEMPO;
						g_first = meta_q;
						g_val   = val_n;
						g_len   = count_n;
					end
				end
				default: begin
					phase_n = PH_DELTA;
				end
			endcase

			// first data byte, or meta type under meta status
			if (do_first) begin
				first_n = b;
				g_first = b;
				g_len   = count_n;
				case (rs_q[7:4])
					4'hC: begin
						give   = 1'b1;
						g_kind = KIND_PROG;
					end
					4'hD: begin
						give   = 1'b1;
						g_kind = KIND_CHAN_PRESS;
					end
					4'hF: begin
						if (rs_q != STATUS_META) begin
							give    = 1'b1;
							g_kind  = KIND_SYS;
							g_first = 8'h00;
						end else begin
							meta_n = b;
							case (b)
								META_LOOP_END: begin
									skip_n  = 3'd6;
									phase_n = PH_SKIP;
								end
								META_LOOP_START: begin
									skip_n  = 3'd2;
									phase_n = PH_SKIP;
								end
								META_TEMPO: begin
									skip_n  = 3'd3;
									val_n   = 32'd0;
									phase_n = PH_TEMPO;
								end
								META_END: begin
									give    = 1'b1;
									g_kind  = KIND_END;
									ended_n = 1'b1;
								end
								default: begin
									give   = 1'b1;
									g_kind = KIND_META;
								end
							endcase
						end
					end
					default: begin
						phase_n = PH_SECOND;
					end
				endcase
			end
		end

		// an event closes: per-event state starts over
		if (give) begin
			phase_n  = PH_DELTA;
			delta_n  = 32'd0;
			val_n    = 32'd0;
			first_n  = 8'h00;
			second_n = 8'h00;
			skip_n   = 3'd0;
			count_n  = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			rs_q     <= 8'h00;
			chan_q   <= 4'h0;
			delta_q  <= 32'd0;
			val_q    <= 32'd0;
			first_q  <= 8'h00;
			second_q <= 8'h00;
			meta_q   <= 8'h00;
			skip_q   <= 3'd0;
			count_q  <= 16'd0;
			ended_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			rs_q     <= rs_n;
			chan_q   <= chan_n;
			delta_q  <= delta_n;
			val_q    <= val_n;
			first_q  <= first_n;
			second_q <= second_n;
			meta_q   <= meta_n;
			skip_q   <= skip_n;
			count_q  <= count_n;
			ended_q  <= ended_n;
		end
	end

	assign ev_valid = give;
	assign ev = '{
		kind:         g_kind,
		channel:      chan_n,
		first_data:   g_first,
		second_data:  g_second,
		value:        g_val,
		delta_time:   delta_q,
		event_length: g_len
	};

endmodule
